FILE: rtl/ttc_pkg.sv
// Package for the text token classifier: phase and kind enums, character
// constants and the result item struct. No dependencies.
package ttc_pkg;

  // Scanner phase between bytes
  typedef enum logic [1:0] {
    ScanIdle  = 2'd0,
    ScanWord  = 2'd1,
    ScanQuote = 2'd2
  } scan_phase_e;

  // Number grammar tracker
  typedef enum logic [2:0] {
    NumStart  = 3'd0,
    NumSign   = 3'd1,
    NumInt    = 3'd2,
    NumFrac   = 3'd3,
    NumSuffix = 3'd4,
    NumBad    = 3'd5
  } num_phase_e;

  // Token kinds as seen on the output
  typedef enum logic [2:0] {
    KindString = 3'd0,
    KindInt    = 3'd1,
    KindFloat  = 3'd2,
    KindTrue   = 3'd3,
    KindFalse  = 3'd4,
    KindEnd    = 3'd5
  } token_kind_e;

  localparam logic [7:0] ChQuote = 8'h22;
  localparam logic [7:0] ChLowF  = 8'h66;
  localparam logic [7:0] ChDot   = 8'h2E;
  localparam logic [7:0] ChMinus = 8'h2D;
  localparam logic [7:0] ChPlus  = 8'h2B;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChTab   = 8'h09;
  localparam logic [7:0] ChCr    = 8'h0D;
  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChNine  = 8'h39;
  localparam logic [7:0] CaseBit = 8'h20;

  // Result queue depth and pointer widths
  localparam int unsigned QDepth = 4;
  localparam int unsigned QPtrW  = 2;
  localparam int unsigned QCntW  = 3;

  // One result item
  typedef struct packed {
    token_kind_e  kind;
    logic [31:0]  start;
    logic [31:0]  length;
    logic         last;
  } result_t;

  // Character of "true" at a word index
  function automatic logic [7:0] kw_true_char(input logic [1:0] idx);
    logic [7:0] ch;
    unique case (idx)
      2'd0:    ch = 8'h74;
      2'd1:    ch = 8'h72;
      2'd2:    ch = 8'h75;
      default: ch = 8'h65;
    endcase
    return ch;
  endfunction

  // Character of "false" at a word index
  function automatic logic [7:0] kw_false_char(input logic [2:0] idx);
    logic [7:0] ch;
    unique case (idx)
      3'd0:    ch = 8'h66;
      3'd1:    ch = 8'h61;
      3'd2:    ch = 8'h6C;
      3'd3:    ch = 8'h73;
      default: ch = 8'h65;
    endcase
    return ch;
  endfunction

endpackage

FILE: rtl/text_token_classifier_top.sv
// Top level of the text token classifier: byte scanner with running state
// and a four-entry result queue. Depends on ttc_pkg.
//
// A result item is written to the result queue when the byte that ends its
// token is accepted. Throughput: one byte per cycle, limited by the result
// queue; input is taken while at least two queue entries are free.
// Reset (async, active low) clears scanner state, offsets, queue and
// words_only.
module text_token_classifier_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  text_byte_i,
  input  logic        end_of_input_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  token_kind_o,
  output logic [31:0] token_start_o,
  output logic [31:0] token_length_o,
  output logic        last_o
);

  // Scanner state
  logic                     words_only_q;
  ttc_pkg::scan_phase_e     phase_q, phase_d;
  ttc_pkg::num_phase_e      num_q, num_d;
  logic [1:0]               kw_q, kw_d;
  logic [31:0]              begin_q, begin_d;
  logic [31:0]              pos_q, pos_d;

  // Result queue
  ttc_pkg::result_t         queue_q [ttc_pkg::QDepth];
  logic [ttc_pkg::QPtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [ttc_pkg::QCntW-1:0] count_q, count_d;

  logic                     in_fire, out_fire;
  logic [31:0]              len;
  logic [7:0]               low;
  logic                     is_space, is_quote, is_digit;
  ttc_pkg::num_phase_e      num_in, num_trk;
  logic [1:0]               kw_in, kw_trk;
  logic [31:0]              idx;
  logic                     true_ok, false_ok;
  ttc_pkg::token_kind_e     kind_ws, kind_quote;
  ttc_pkg::result_t         res0, res1;
  logic [1:0]               n_res;

  function automatic logic [ttc_pkg::QCntW-1:0] QCntWn(input logic [1:0] n);
    return {{(ttc_pkg::QCntW-2){1'b0}}, n};
  endfunction

  assign in_ready_o = (count_q <= ttc_pkg::QCntW'(ttc_pkg::QDepth - 2));
  assign in_fire    = in_valid_i & in_ready_o;
  assign out_valid_o = (count_q != '0);
  assign out_fire   = out_valid_o & out_ready_i;

  // Classify the byte
  assign len      = pos_q - begin_q;
  assign low      = text_byte_i | ttc_pkg::CaseBit;
  assign is_space = (text_byte_i == ttc_pkg::ChSpace) ||
                    ((text_byte_i >= ttc_pkg::ChTab) && (text_byte_i <= ttc_pkg::ChCr));
  assign is_quote = (text_byte_i == ttc_pkg::ChQuote);
  assign is_digit = (text_byte_i >= ttc_pkg::ChZero) && (text_byte_i <= ttc_pkg::ChNine);

  // Track number grammar and keyword candidates; a new word starts fresh
  always_comb begin
    if (phase_q == ttc_pkg::ScanIdle) begin
      num_in = ttc_pkg::NumStart;
      kw_in  = 2'b11;
      idx    = '0;
    end else begin
      num_in = num_q;
      kw_in  = kw_q;
      idx    = len;
    end
    case (num_in)
      ttc_pkg::NumStart: begin
        if (text_byte_i == ttc_pkg::ChMinus || text_byte_i == ttc_pkg::ChPlus) begin
          num_trk = ttc_pkg::NumSign;
        end else if (is_digit) begin
          num_trk = ttc_pkg::NumInt;
        end else begin
          num_trk = ttc_pkg::NumBad;
        end
      end
      ttc_pkg::NumSign: begin
        num_trk = is_digit ? ttc_pkg::NumInt : ttc_pkg::NumBad;
      end
      ttc_pkg::NumInt: begin
        if (is_digit) begin
          num_trk = ttc_pkg::NumInt;
        end else if (text_byte_i == ttc_pkg::ChDot) begin
          num_trk = ttc_pkg::NumFrac;
        end else if (text_byte_i == ttc_pkg::ChLowF) begin
          num_trk = ttc_pkg::NumSuffix;
        end else begin
          num_trk = ttc_pkg::NumBad;
        end
      end
      ttc_pkg::NumFrac: begin
        if (is_digit) begin
          num_trk = ttc_pkg::NumFrac;
        end else if (text_byte_i == ttc_pkg::ChLowF) begin
          num_trk = ttc_pkg::NumSuffix;
        end else begin
          num_trk = ttc_pkg::NumBad;
        end
      end
      default: num_trk = ttc_pkg::NumBad;
    endcase
    true_ok  = (idx < 32'd4) && (low == ttc_pkg::kw_true_char(idx[1:0]));
    false_ok = (idx < 32'd5) && (low == ttc_pkg::kw_false_char(idx[2:0]));
    kw_trk   = kw_in & {false_ok, true_ok};
  end

  // Kind of the finished word, ended by whitespace/end or by a quote
  always_comb begin
    kind_ws    = ttc_pkg::KindString;
    kind_quote = ttc_pkg::KindString;
    if (!words_only_q) begin
      if (kw_q[0] && len == 32'd4) begin
        kind_quote = ttc_pkg::KindTrue;
      end else if (kw_q[1] && len == 32'd5) begin
        kind_quote = ttc_pkg::KindFalse;
      end
      if (num_q == ttc_pkg::NumInt) begin
        kind_ws = ttc_pkg::KindInt;
      end else if (num_q == ttc_pkg::NumFrac || num_q == ttc_pkg::NumSuffix) begin
        kind_ws = ttc_pkg::KindFloat;
      end else begin
        kind_ws = kind_quote;
      end
    end
  end

  // Next state and result items for the accepted item
  always_comb begin
    phase_d = phase_q;
    num_d   = num_q;
    kw_d    = kw_q;
    begin_d = begin_q;
    pos_d   = pos_q;
    n_res   = 2'd0;
    res0    = '{kind: ttc_pkg::KindString, start: begin_q, length: len, last: 1'b1};
    res1    = '{kind: ttc_pkg::KindEnd, start: pos_q, length: '0, last: 1'b1};
    if (in_fire) begin
      pos_d = pos_q + 32'd1;
      if (end_of_input_i) begin
        // Flush pending token, then the end token; restart
        unique case (phase_q)
          ttc_pkg::ScanWord: begin
            res0.kind = kind_ws;
            res0.last = 1'b0;
            n_res     = 2'd2;
          end
          ttc_pkg::ScanQuote: begin
            res0.last = 1'b0;
            n_res     = 2'd2;
          end
          default: begin
            res0  = res1;
            n_res = 2'd1;
          end
        endcase
        phase_d = ttc_pkg::ScanIdle;
        num_d   = ttc_pkg::NumStart;
        kw_d    = 2'b11;
        begin_d = '0;
        pos_d   = '0;
      end else begin
        unique case (phase_q)
          ttc_pkg::ScanWord: begin
            if (is_space) begin
              res0.kind = kind_ws;
              n_res     = 2'd1;
              phase_d   = ttc_pkg::ScanIdle;
            end else if (is_quote) begin
              res0.kind = kind_quote;
              n_res     = 2'd1;
              phase_d   = ttc_pkg::ScanQuote;
              begin_d   = pos_q + 32'd1;
            end else begin
              num_d = num_trk;
              kw_d  = kw_trk;
            end
          end
          ttc_pkg::ScanQuote: begin
            if (is_quote) begin
              n_res   = 2'd1;
              phase_d = ttc_pkg::ScanIdle;
            end
          end
          default: begin
            if (is_quote) begin
              phase_d = ttc_pkg::ScanQuote;
              begin_d = pos_q + 32'd1;
            end else if (!is_space) begin
              phase_d = ttc_pkg::ScanWord;
              begin_d = pos_q;
              num_d   = num_trk;
              kw_d    = kw_trk;
            end
          end
        endcase
      end
    end
  end

  assign count_d = count_q + QCntWn(n_res) - {{(ttc_pkg::QCntW-1){1'b0}}, out_fire};

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      words_only_q <= 1'b0;
      phase_q      <= ttc_pkg::ScanIdle;
      num_q        <= ttc_pkg::NumStart;
      kw_q         <= 2'b11;
      begin_q      <= '0;
      pos_q        <= '0;
      wr_ptr_q     <= '0;
      rd_ptr_q     <= '0;
      count_q      <= '0;
    end else begin
      if (cfg_we_i) begin
        words_only_q <= cfg_wdata_i;
      end
      phase_q  <= phase_d;
      num_q    <= num_d;
      kw_q     <= kw_d;
      begin_q  <= begin_d;
      pos_q    <= pos_d;
      wr_ptr_q <= wr_ptr_q + n_res;
      if (out_fire) begin
        rd_ptr_q <= rd_ptr_q + 2'd1;
      end
      count_q  <= count_d;
    end
  end

  // Push result items into the queue
  always_ff @(posedge clk_i) begin
    if (n_res != 2'd0) begin
      queue_q[wr_ptr_q] <= res0;
    end
    if (n_res == 2'd2) begin
      queue_q[wr_ptr_q + 2'd1] <= res1;
    end
  end

  // Drive the head item
  assign token_kind_o   = queue_q[rd_ptr_q].kind;
  assign token_start_o  = queue_q[rd_ptr_q].start;
  assign token_length_o = queue_q[rd_ptr_q].length;
  assign last_o         = queue_q[rd_ptr_q].last;

endmodule

FILE: tb/testbench.sv
// Self-checking testbench for text_token_classifier_top: directed and random
// byte streams, a token predictor and a result checker. Depends on ttc_pkg.
module testbench;

  localparam int unsigned CycleLimit = 100_000;
  localparam logic [31:0] TrueText  = "true";
  localparam logic [39:0] FalseText = "false";

  // One input item: a text byte or an end-of-input marker
  typedef struct packed {
    logic [7:0] text;
    logic       eoi;
  } text_item_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic        cfg_wdata_i = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [7:0]  text_byte_i = 8'h00;
  logic        end_of_input_i = 1'b0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [2:0]  token_kind_o;
  logic [31:0] token_start_o;
  logic [31:0] token_length_o;
  logic        last_o;

  text_token_classifier_top dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .text_byte_i    (text_byte_i),
    .end_of_input_i (end_of_input_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .token_kind_o   (token_kind_o),
    .token_start_o  (token_start_o),
    .token_length_o (token_length_o),
    .last_o         (last_o)
  );

  always #5 clk_i = ~clk_i;

  text_item_t        pending_text[$];
  ttc_pkg::result_t  expected_tokens[$];
  text_item_t        next_item;
  ttc_pkg::result_t  want;
  int unsigned cycle = 0;
  int unsigned mismatches = 0;
  int unsigned items_accepted = 0;
  int unsigned tokens_seen = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned stall_requests = 0;
  int unsigned stall_served = 0;
  int unsigned stall_left = 0;

  // Predictor state, mirrors the scanner after reset
  ttc_pkg::scan_phase_e scan_st = ttc_pkg::ScanIdle;
  ttc_pkg::num_phase_e  num_st = ttc_pkg::NumStart;
  logic [1:0]  kw_live = 2'b11;
  logic [31:0] tok_begin = 32'd0;
  logic [31:0] byte_pos = 32'd0;
  logic        words_only_q = 1'b0;

  function automatic logic is_blank(input logic [7:0] b);
    return b == ttc_pkg::ChSpace || (b >= ttc_pkg::ChTab && b <= ttc_pkg::ChCr);
  endfunction

  function automatic logic is_digit(input logic [7:0] b);
    return b >= ttc_pkg::ChZero && b <= ttc_pkg::ChNine;
  endfunction

  function automatic ttc_pkg::result_t token_item(input ttc_pkg::token_kind_e k,
                                                  input logic [31:0] s,
                                                  input logic [31:0] l);
    ttc_pkg::result_t r;
    r.kind = k;
    r.start = s;
    r.length = l;
    r.last = 1'b0;
    return r;
  endfunction

  // Advance the number grammar and keyword match by one word character
  task automatic track_char(input logic [7:0] b, input logic [31:0] idx);
    logic [7:0] low;
    low = b | ttc_pkg::CaseBit;
    case (num_st)
      ttc_pkg::NumStart: begin
        if (b == ttc_pkg::ChMinus || b == ttc_pkg::ChPlus) num_st = ttc_pkg::NumSign;
        else if (is_digit(b)) num_st = ttc_pkg::NumInt;
        else num_st = ttc_pkg::NumBad;
      end
      ttc_pkg::NumSign: num_st = is_digit(b) ? ttc_pkg::NumInt : ttc_pkg::NumBad;
      ttc_pkg::NumInt: begin
        if (is_digit(b)) num_st = ttc_pkg::NumInt;
        else if (b == ttc_pkg::ChDot) num_st = ttc_pkg::NumFrac;
        else if (b == ttc_pkg::ChLowF) num_st = ttc_pkg::NumSuffix;
        else num_st = ttc_pkg::NumBad;
      end
      ttc_pkg::NumFrac: begin
        if (is_digit(b)) num_st = ttc_pkg::NumFrac;
        else if (b == ttc_pkg::ChLowF) num_st = ttc_pkg::NumSuffix;
        else num_st = ttc_pkg::NumBad;
      end
      default: num_st = ttc_pkg::NumBad;
    endcase
    if (idx >= 4 || low != TrueText[31 - 8 * int'(idx[1:0]) -: 8]) kw_live[0] = 1'b0;
    if (idx >= 5 || low != FalseText[39 - 8 * int'(idx[2:0]) -: 8]) kw_live[1] = 1'b0;
  endtask

  // Kind of a finished word; numbers only count when ended by blank or end
  function automatic ttc_pkg::token_kind_e word_kind(input logic numeric_ok,
                                                     input logic [31:0] len);
    if (words_only_q) return ttc_pkg::KindString;
    if (numeric_ok && num_st == ttc_pkg::NumInt) return ttc_pkg::KindInt;
    if (numeric_ok && (num_st == ttc_pkg::NumFrac || num_st == ttc_pkg::NumSuffix))
      return ttc_pkg::KindFloat;
    if (kw_live[0] && len == 32'd4) return ttc_pkg::KindTrue;
    if (kw_live[1] && len == 32'd5) return ttc_pkg::KindFalse;
    return ttc_pkg::KindString;
  endfunction

  // Predict the tokens that one accepted item finishes
  task automatic classify_item(input logic [7:0] b, input logic eoi);
    ttc_pkg::result_t made[2];
    int               n;
    logic [31:0]      len;
    n = 0;
    len = byte_pos - tok_begin;
    if (eoi) begin
      if (scan_st == ttc_pkg::ScanWord) begin
        made[n] = token_item(word_kind(1'b1, len), tok_begin, len);
        n++;
      end else if (scan_st == ttc_pkg::ScanQuote) begin
        made[n] = token_item(ttc_pkg::KindString, tok_begin, len);
        n++;
      end
      made[n] = token_item(ttc_pkg::KindEnd, byte_pos, 32'd0);
      n++;
      scan_st = ttc_pkg::ScanIdle;
      num_st = ttc_pkg::NumStart;
      kw_live = 2'b11;
      tok_begin = 32'd0;
      byte_pos = 32'd0;
    end else begin
      if (scan_st == ttc_pkg::ScanWord) begin
        if (is_blank(b)) begin
          made[n] = token_item(word_kind(1'b1, len), tok_begin, len);
          n++;
          scan_st = ttc_pkg::ScanIdle;
        end else if (b == ttc_pkg::ChQuote) begin
          made[n] = token_item(word_kind(1'b0, len), tok_begin, len);
          n++;
          scan_st = ttc_pkg::ScanQuote;
          tok_begin = byte_pos + 32'd1;
        end else begin
          track_char(b, len);
        end
      end else if (scan_st == ttc_pkg::ScanQuote) begin
        if (b == ttc_pkg::ChQuote) begin
          made[n] = token_item(ttc_pkg::KindString, tok_begin, len);
          n++;
          scan_st = ttc_pkg::ScanIdle;
        end
      end else if (b == ttc_pkg::ChQuote) begin
        scan_st = ttc_pkg::ScanQuote;
        tok_begin = byte_pos + 32'd1;
      end else if (!is_blank(b)) begin
        scan_st = ttc_pkg::ScanWord;
        tok_begin = byte_pos;
        num_st = ttc_pkg::NumStart;
        kw_live = 2'b11;
        track_char(b, 32'd0);
      end
      byte_pos = byte_pos + 32'd1;
    end
    for (int i = 0; i < n; i++) begin
      made[i].last = (i == n - 1);
      expected_tokens.push_back(made[i]);
    end
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] exp_val);
    mismatches++;
    $display("MISMATCH cycle %0d token %0d: %s got %0h expected %0h",
             cycle, tokens_seen, what, got, exp_val);
  endtask

  // Drive: offer queued items, predict on each accepted one
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        classify_item(text_byte_i, end_of_input_i);
        items_accepted++;
      end
      if (!in_valid_i || in_ready_o) begin
        if (pending_text.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          next_item = pending_text.pop_front();
          in_valid_i <= 1'b1;
          text_byte_i <= next_item.text;
          end_of_input_i <= next_item.eoi;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each accepted result item, then pick the next ready
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        tokens_seen++;
        if (expected_tokens.size() == 0) begin
          report_mismatch("unexpected item, kind", 32'(token_kind_o), 32'd0);
        end else begin
          want = expected_tokens.pop_front();
          if (token_kind_o !== want.kind)
            report_mismatch("kind", 32'(token_kind_o), 32'(want.kind));
          if (token_start_o !== want.start) report_mismatch("start", token_start_o, want.start);
          if (token_length_o !== want.length)
            report_mismatch("length", token_length_o, want.length);
          if (last_o !== want.last) report_mismatch("last", 32'(last_o), 32'(want.last));
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ready_i <= 1'b0;
      end else if (stall_served != stall_requests) begin
        stall_served++;
        stall_left = 80;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= $urandom_range(99) >= recv_idle_pct;
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle++;
    if (cycle >= CycleLimit) begin
      $display("Timeout after %0d cycles, %0d tokens still expected",
               cycle, expected_tokens.size());
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic queue_byte(input logic [7:0] b);
    text_item_t it;
    it.text = b;
    it.eoi = 1'b0;
    pending_text.push_back(it);
  endtask

  task automatic queue_end();
    text_item_t it;
    it.text = 8'($urandom_range(255));
    it.eoi = 1'b1;
    pending_text.push_back(it);
  endtask

  task automatic queue_text(input string s);
    for (int i = 0; i < s.len(); i++) queue_byte(s[i]);
  endtask

  function automatic logic [7:0] word_char();
    logic [7:0] c;
    c = 8'($urandom_range(8'h23, 8'h7E));
    return c;
  endfunction

  function automatic logic [7:0] blank_char();
    logic [7:0] c;
    int unsigned r;
    r = $urandom_range(5);
    c = (r == 5) ? ttc_pkg::ChSpace : 8'(ttc_pkg::ChTab + r);
    return c;
  endfunction

  function automatic logic [7:0] digit_char();
    logic [7:0] c;
    c = 8'(ttc_pkg::ChZero + $urandom_range(9));
    return c;
  endfunction

  // Sign, digits, optional fraction and suffix, sometimes spoiled
  task automatic queue_number();
    if ($urandom_range(2) == 0)
      queue_byte($urandom_range(1) ? ttc_pkg::ChMinus : ttc_pkg::ChPlus);
    repeat ($urandom_range(0, 4)) queue_byte(digit_char());
    if ($urandom_range(1)) begin
      queue_byte(ttc_pkg::ChDot);
      repeat ($urandom_range(0, 3)) queue_byte(digit_char());
    end
    if ($urandom_range(3) == 0) queue_byte(ttc_pkg::ChLowF);
    if ($urandom_range(9) == 0) queue_byte(word_char());
  endtask

  // true or false in mixed case, sometimes cut short or extended
  task automatic queue_keyword();
    string      kw;
    int         n;
    logic [7:0] c;
    if ($urandom_range(1)) kw = "true";
    else kw = "false";
    n = kw.len();
    if ($urandom_range(7) == 0) n--;
    for (int i = 0; i < n; i++) begin
      c = kw[i];
      if ($urandom_range(1)) c = c & ~ttc_pkg::CaseBit;
      queue_byte(c);
    end
    if ($urandom_range(7) == 0) queue_byte(word_char());
  endtask

  // One random token or noise, mostly followed by blanks
  task automatic queue_random_chunk();
    int unsigned pick;
    logic [7:0]  c;
    pick = $urandom_range(99);
    if (pick < 25) begin
      queue_number();
    end else if (pick < 40) begin
      queue_keyword();
    end else if (pick < 55) begin
      repeat ($urandom_range(1, 5)) queue_byte(word_char());
    end else if (pick < 70) begin
      queue_byte(ttc_pkg::ChQuote);
      repeat ($urandom_range(0, 5)) begin
        c = 8'($urandom_range(255));
        queue_byte(c == ttc_pkg::ChQuote ? ttc_pkg::ChSpace : c);
      end
      if ($urandom_range(9) != 0) queue_byte(ttc_pkg::ChQuote);
    end else if (pick < 80) begin
      repeat ($urandom_range(1, 3)) queue_byte(8'($urandom_range(255)));
    end else if (pick < 86) begin
      queue_end();
    end
    if ($urandom_range(9) < 7) repeat ($urandom_range(1, 2)) queue_byte(blank_char());
  endtask

  task automatic queue_random_text(input int unsigned count);
    int unsigned target;
    target = pending_text.size() + count;
    while (pending_text.size() < target) queue_random_chunk();
    queue_end();
  endtask

  // Hold until every item is in and every token is out, then let the
  // pipeline settle
  task automatic wait_drained();
    @(negedge clk_i);
    while (pending_text.size() > 0 || in_valid_i || expected_tokens.size() > 0)
      @(negedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_words_only(input logic value);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= value;
    words_only_q = value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: byte extremes, int, float with dot and suffix, sign before a letter,
    // empty quotes, keyword ended by a quote, unterminated string, number
    // ended by a quote, mixed-case keyword and trailing blank
    write_words_only(1'b0);
    send_idle_pct = 12;
    recv_idle_pct = 56;
    @(negedge clk_i);
    queue_byte(8'h00);
    queue_text(" 7 -3.f +x\"\"FALSE\"");
    queue_byte(8'hFF);
    queue_end();
    queue_text("12\"");
    queue_end();
    queue_text("tRue ");
    queue_end();
    queue_random_text(150);
    wait_drained();

    write_words_only(1'b1);
    send_idle_pct = 56;
    recv_idle_pct = 12;
    @(negedge clk_i);
    queue_random_text(100);
    wait_drained();

    // No idling, with one long output stall to back up the input
    write_words_only(1'b0);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    @(negedge clk_i);
    stall_requests++;
    queue_random_text(150);
    wait_drained();

    repeat (10) @(posedge clk_i);
    $display("Ran %0d input items and checked %0d tokens", items_accepted, tokens_seen);
    $display("with words_only off and on, mixed idling and a long output stall");
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
